// ----- design/apa_pkg.sv -----
package apa_pkg;

  localparam int HostBitsMin = 3;
  localparam int PrefixRst   = 22;
  localparam int UsedInit    = 3;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_NOFREE  = 3'd2,
    ST_INVALID = 3'd3,
    ST_ALREADY = 3'd4
  } status_e;

  typedef enum logic {
    CFG_SUBNET = 1'b0,
    CFG_PREFIX = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_CLIMB,
    S_MARK,
    S_MARK_CHK,
    S_FREE_CHK,
    S_FREE_UP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
  } apa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [10:0] free_count;
  } apa_out_t;

endpackage

// ----- design/address_pool_allocator_unit.sv -----
// Address pool allocator. Hands out host addresses of one subnet from a complete binary tree
// of full marks kept in a 1-bit memory (node 1 is the root, node n has children 2n and 2n+1,
// leaves at depth H are the hosts; H = 32 - prefix_length clamped to 3..MAX_HOST_BITS).
// One transaction is worked on at a time; the tree memory has one write and one read port and
// a registered read. Allocate reads one level at a time on the way down, climbs back and moves
// on to the next host when the requested one is taken, then marks the leaf full and each
// ancestor whose other child is also full. Free clears the leaf and each full ancestor above
// it, and reports ST_ALREADY when the host is already free; a reserved host is refused as
// invalid and an unused command changes nothing. Reinitialize runs a clearing pass over
// 2^(H+1) tree entries before its result; the same pass runs after reset and after every
// prefix_length write, during which no transaction is accepted. Results sit in an output
// register, so the next transaction is taken while a result waits.
module address_pool_allocator_unit
  import apa_pkg::*;
#(
  parameter int MAX_HOST_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  apa_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output apa_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int HW = MAX_HOST_BITS;
  localparam int NW = MAX_HOST_BITS + 1;
  localparam int CW = MAX_HOST_BITS + 1;
  localparam int DW = $clog2(MAX_HOST_BITS + 1);
  localparam int PW = $clog2(MAX_HOST_BITS);
  localparam int HbRst = (MAX_HOST_BITS < 32 - PrefixRst) ? MAX_HOST_BITS : 32 - PrefixRst;

  function automatic logic [DW-1:0] host_width(input logic [4:0] p);
    logic [5:0] hw;
    logic [5:0] r;
    hw = 6'd32 - {1'b0, p};
    if (hw > 6'(MAX_HOST_BITS)) begin
      r = 6'(MAX_HOST_BITS);
    end else if (hw < 6'(HostBitsMin)) begin
      r = 6'(HostBitsMin);
    end else begin
      r = hw;
    end
    return DW'(r);
  endfunction

  function automatic logic [HW-1:0] bump(input logic [HW-1:0] h, input logic [PW-1:0] p);
    return (h & ({HW{1'b1}} << p)) | (HW'(1) << p);
  endfunction

  state_e        state_q, state_d;
  logic [NW-1:0] node_q, node_d;
  logic [DW-1:0] d_q, d_d;
  logic [HW-1:0] host_q, host_d;
  status_e       status_q, status_d;
  logic [31:0]   grant_q, grant_d;
  logic [NW-1:0] clr_q, clr_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] used_q, used_d;
  logic [DW-1:0] hb_q, hb_d;
  logic [31:0]   subnet_q, subnet_d;
  apa_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [NW-1:0] mem_raddr;
  logic          mem_rdata;

  logic [HW-1:0] hmask;
  logic [31:0]   mask32;
  logic [NW-1:0] leaf_base;
  logic [NW-1:0] tree_last;
  logic [CW-1:0] total;
  logic [CW-1:0] freec;
  logic [HW-1:0] host_in;
  logic [PW-1:0] pos;
  logic          bit_sel;
  logic [NW-1:0] child;
  logic          init_val;

  apa_tree_mem #(
    .AW(NW)
  ) u_tree_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign hmask     = ~({HW{1'b1}} << hb_q);
  assign mask32    = ~(32'hFFFF_FFFF << hb_q);
  assign leaf_base = NW'(1) << hb_q;
  assign tree_last = ((NW'(1) << hb_q) << 1) - NW'(1);
  assign total     = CW'(1) << hb_q;
  assign freec     = (used_q <= total) ? total - used_q : '0;
  assign host_in   = in_data_i.address[HW-1:0] & hmask;
  assign pos       = PW'(hb_q - DW'(1) - d_q);
  assign bit_sel   = host_q[pos];
  assign child     = {node_q[NW-2:0], bit_sel};
  assign init_val  = (clr_q == leaf_base) || (clr_q == leaf_base - NW'(1)) ||
                     (clr_q == tree_last) || (clr_q == tree_last - NW'(1));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      used_q      <= CW'(UsedInit);
      hb_q        <= DW'(HbRst);
      subnet_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      used_q      <= used_d;
      hb_q        <= hb_d;
      subnet_q    <= subnet_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    d_q      <= d_d;
    host_q   <= host_d;
    status_q <= status_d;
    grant_q  <= grant_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    d_d         = d_q;
    host_d      = host_q;
    status_d    = status_q;
    grant_d     = grant_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    used_d      = used_q;
    hb_d        = hb_q;
    subnet_d    = subnet_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = 1'b0;
    mem_raddr   = node_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          host_d   = host_in;
          grant_d  = '0;
          status_d = ST_OK;
          unique case (cmd_e'(in_data_i.cmd))
            CMD_ALLOC: begin
              node_d  = NW'(1);
              d_d     = '0;
              state_d = S_ALLOC_RD;
            end
            CMD_FREE: begin
              if (host_in == '0 || host_in == hmask || host_in == hmask - HW'(1)) begin
                status_d = ST_INVALID;
                state_d  = S_DONE;
              end else begin
                mem_raddr = leaf_base | NW'(host_in);
                node_d    = leaf_base | NW'(host_in);
                state_d   = S_FREE_CHK;
              end
            end
            CMD_INIT: begin
              clr_d   = '0;
              pend_d  = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = init_val;
        clr_d     = clr_q + NW'(1);
        if (clr_q == tree_last) begin
          used_d  = CW'(UsedInit);
          pend_d  = 1'b0;
          state_d = pend_q ? S_DONE : S_IDLE;
        end
      end
      S_ALLOC_RD: begin
        mem_raddr = child;
        state_d   = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (!mem_rdata) begin
          node_d  = child;
          d_d     = d_q + DW'(1);
          state_d = (d_q + DW'(1) == hb_q) ? S_MARK : S_ALLOC_RD;
        end else if (!bit_sel) begin
          host_d   = bump(host_q, pos);
          status_d = ST_TAKEN;
          state_d  = S_ALLOC_RD;
        end else begin
          status_d = ST_TAKEN;
          state_d  = S_CLIMB;
        end
      end
      S_CLIMB: begin
        if (node_q == NW'(1)) begin
          status_d = ST_NOFREE;
          state_d  = S_DONE;
        end else begin
          node_d = node_q >> 1;
          d_d    = d_q - DW'(1);
          if (!node_q[0]) begin
            host_d  = bump(host_q, PW'(hb_q - d_q));
            state_d = S_ALLOC_RD;
          end
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = 1'b1;
        mem_raddr = node_q ^ NW'(1);
        if (node_q == NW'(1)) begin
          used_d  = used_q + CW'(1);
          grant_d = (subnet_q & ~mask32) | 32'(host_q);
          state_d = S_DONE;
        end else begin
          state_d = S_MARK_CHK;
        end
      end
      S_MARK_CHK: begin
        if (mem_rdata) begin
          node_d  = node_q >> 1;
          state_d = S_MARK;
        end else begin
          used_d  = used_q + CW'(1);
          grant_d = (subnet_q & ~mask32) | 32'(host_q);
          state_d = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (!mem_rdata) begin
          status_d = ST_ALREADY;
          state_d  = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = node_q;
          mem_wdata = 1'b0;
          mem_raddr = node_q >> 1;
          node_d    = node_q >> 1;
          state_d   = S_FREE_UP;
        end
      end
      S_FREE_UP: begin
        if (node_q != '0 && mem_rdata) begin
          mem_we    = 1'b1;
          mem_waddr = node_q;
          mem_wdata = 1'b0;
          mem_raddr = node_q >> 1;
          node_d    = node_q >> 1;
        end else begin
          if (used_q != '0) begin
            used_d = used_q - CW'(1);
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status          = status_q;
          out_d.granted_address = grant_q;
          out_d.free_count      = 11'(freec);
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SUBNET: begin
          subnet_d = cfg_data_i;
        end
        CFG_PREFIX: begin
          hb_d    = host_width(cfg_data_i[4:0]);
          clr_d   = '0;
          state_d = S_CLEAR;
        end
        default: begin
          subnet_d = subnet_q;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_used_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (used_q <= total))
    else $error("used count exceeds pool size");

  a_depth_in_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC_RD || state_q == S_ALLOC_CHK) |-> (d_q < hb_q))
    else $error("allocate walk below leaf level");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != S_IDLE && state_q != S_DONE))
    else $error("tree write while no transaction in progress");
`endif

endmodule

// ----- design/apa_tree_mem.sv -----
module apa_tree_mem #(
  parameter int AW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [2**AW];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/tb_address_pool_allocator_unit.sv -----
`timescale 1ns / 1ps

module tb_address_pool_allocator_unit;
  import apa_pkg::*;

  localparam int MaxHostBits = 10;
  localparam int TreeNodes = 2 ** (MaxHostBits + 1);
  localparam int ClearCycles = TreeNodes + 64;
  localparam int EndCycles = 40;
  localparam int WatchdogLimit = 20000;
  localparam int PhaseItems = 92;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  apa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  apa_out_t    out_data;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_index = CFG_SUBNET;
  logic [31:0] cfg_data = '0;

  int in_idle_pct = 18;
  int out_idle_pct = 49;
  int n_errors = 0;
  int idle_cycles = 0;

  // pool model
  bit          tree_full [TreeNodes];
  logic [31:0] subnet_reg;
  logic [4:0]  prefix_reg;
  int unsigned host_w;
  int unsigned used_hosts;

  apa_out_t    expected_replies [$];
  int unsigned granted_hosts [$];

  address_pool_allocator_unit #(
    .MAX_HOST_BITS(MaxHostBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned host_mask();
    return (32'd1 << host_w) - 32'd1;
  endfunction

  function automatic void set_host_width();
    int unsigned h;
    h = 32 - prefix_reg;
    if (h > MaxHostBits) h = MaxHostBits;
    if (h < HostBitsMin) h = HostBitsMin;
    host_w = h;
  endfunction

  function automatic void mark_full(input int unsigned host);
    int unsigned node;
    node = (32'd1 << host_w) | (host & host_mask());
    tree_full[node] = 1'b1;
    while (node > 1 && tree_full[node ^ 1]) begin
      node = node >> 1;
      tree_full[node] = 1'b1;
    end
  endfunction

  function automatic void reset_pool();
    foreach (tree_full[i]) tree_full[i] = 1'b0;
    mark_full(0);
    mark_full(host_mask() - 1);
    mark_full(host_mask());
    used_hosts = UsedInit;
  endfunction

  function automatic status_e grab_host(input int unsigned req, output int unsigned got);
    int unsigned host, node, depth, pos, dir, child;
    status_e st;
    host = req;
    node = 1;
    depth = 0;
    st = ST_OK;
    got = 0;
    while (depth < host_w) begin
      pos = host_w - 1 - depth;
      dir = (host >> pos) & 1;
      child = (node << 1) | dir;
      if (!tree_full[child]) begin
        node = child;
        depth++;
      end else begin
        st = ST_TAKEN;
        if (dir == 0) begin
          host = (host | (32'd1 << pos)) & ~((32'd1 << pos) - 32'd1);
        end else begin
          while (node > 1 && (node & 1) != 0) begin
            node = node >> 1;
            depth--;
          end
          if (node == 1) return ST_NOFREE;
          node = node >> 1;
          depth--;
          pos = host_w - 1 - depth;
          host = (host | (32'd1 << pos)) & ~((32'd1 << pos) - 32'd1);
        end
      end
    end
    mark_full(host);
    used_hosts++;
    got = host;
    return st;
  endfunction

  function automatic status_e release_host(input int unsigned host);
    int unsigned m, node;
    m = host_mask();
    if (host == 0 || host == m || host == m - 1) return ST_INVALID;
    node = (32'd1 << host_w) | host;
    if (!tree_full[node]) return ST_ALREADY;
    tree_full[node] = 1'b0;
    node = node >> 1;
    while (node >= 1 && tree_full[node]) begin
      tree_full[node] = 1'b0;
      node = node >> 1;
    end
    if (used_hosts > 0) used_hosts--;
    return ST_OK;
  endfunction

  function automatic apa_out_t compute_reply(input apa_in_t txn);
    apa_out_t r;
    int unsigned host, got, total;
    status_e st;
    r = '0;
    got = 0;
    st = ST_OK;
    host = txn.address & host_mask();
    case (txn.cmd)
      CMD_ALLOC: begin
        st = grab_host(host, got);
        if (st == ST_OK || st == ST_TAKEN) begin
          r.granted_address = (subnet_reg & ~host_mask()) | got;
          granted_hosts.push_back(got);
        end
      end
      CMD_FREE: st = release_host(host);
      CMD_INIT: begin
        reset_pool();
        granted_hosts.delete();
      end
      default: ;
    endcase
    total = 32'd1 << host_w;
    r.status = st;
    r.free_count = 11'((used_hosts <= total) ? total - used_hosts : 0);
    return r;
  endfunction

  always @(negedge clk) begin
    out_stall <= (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin : scoreboard
    apa_out_t want;
    bit moved;
    moved = 1'b0;
    if (!rst_n) begin
      subnet_reg = '0;
      prefix_reg = 5'(PrefixRst);
      set_host_width();
      reset_pool();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SUBNET) begin
          subnet_reg = cfg_data;
        end else begin
          prefix_reg = cfg_data[4:0];
          set_host_width();
          reset_pool();
          granted_hosts.delete();
        end
      end
      if (in_valid && !in_stall) begin
        expected_replies.push_back(compute_reply(in_data));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_replies.size() == 0) begin
          $error("result transaction with nothing pending");
          n_errors++;
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            n_errors++;
          end
          if (out_data.granted_address !== want.granted_address) begin
            $error("granted_address: expected %h, got %h", want.granted_address,
                   out_data.granted_address);
            n_errors++;
          end
          if (out_data.free_count !== want.free_count) begin
            $error("free_count: expected %0d, got %0d", want.free_count, out_data.free_count);
            n_errors++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("tb_address_pool_allocator_unit: errors");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_txn(input logic [1:0] cmd, input logic [31:0] addr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, address: addr};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle_pool(input int pause);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_pool(input logic [31:0] subnet, input logic [4:0] prefix);
    settle_pool(ClearCycles);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SUBNET;
    cfg_data <= subnet;
    @(negedge clk);
    cfg_index <= CFG_PREFIX;
    cfg_data <= {27'd0, prefix};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_txn(CMD_ALLOC, 32'h0);
    send_txn(CMD_FREE, 32'h3FF);
    send_txn(CMD_ALLOC, 32'hFFFF_FFFF);
    send_txn(CMD_FREE, 32'h1);
  endtask

  task automatic test_alloc_free_cases();
    set_pool($urandom(), 5'd24);
    send_txn(CMD_ALLOC, 32'h0000_005A);
    send_txn(CMD_ALLOC, 32'h0000_005A);
    send_txn(CMD_FREE, 32'hAB00_005A);
    send_txn(CMD_FREE, 32'h0000_005A);
    send_txn(CMD_FREE, 32'h0000_0000);
    send_txn(CMD_FREE, 32'h0000_00FE);
    send_txn(CMD_FREE, 32'hFFFF_FFFF);
    send_txn(CMD_ALLOC, 32'h0000_00FD);
    send_txn(CMD_ALLOC, 32'h0000_00FD);
    send_txn(CmdUnused, 32'hFFFF_FFFF);
    send_txn(CMD_INIT, 32'h1234_5678);
    send_txn(CMD_ALLOC, 32'hFFFF_FF00);
  endtask

  // prefix 31 saturates to three host bits, so five hosts fill the pool
  task automatic test_pool_exhaustion();
    set_pool($urandom(), 5'd31);
    repeat (6) send_txn(CMD_ALLOC, 32'h0);
    send_txn(CMD_FREE, 32'hFFFF_FFF3);
    send_txn(CMD_ALLOC, 32'h0);
  endtask

  task automatic test_random_traffic();
    logic [4:0]  prefix;
    logic [31:0] subnet;
    logic [31:0] addr;
    int unsigned m, idx, roll;
    for (int p = 0; p < 12; p++) begin
      case (p)
        8:       prefix = 5'd0;
        9:       prefix = 5'd30;
        10:      prefix = 5'd31;
        11:      prefix = 5'd29;
        default: prefix = 5'(29 - p);
      endcase
      subnet = (p == 3) ? 32'hFFFF_FFFF : (p == 6) ? 32'h0 : $urandom();
      set_pool(subnet, prefix);
      if (p < 4) begin
        in_idle_pct = 18;
        out_idle_pct = 49;
      end else if (p < 8) begin
        in_idle_pct = 49;
        out_idle_pct = 18;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      m = host_mask();
      repeat (PhaseItems) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          send_txn(CMD_ALLOC, $urandom());
        end else if (roll < 85 && granted_hosts.size() != 0) begin
          idx = $urandom_range(granted_hosts.size() - 1);
          addr = ($urandom() & ~m) | granted_hosts[idx];
          granted_hosts.delete(idx);
          send_txn(CMD_FREE, addr);
        end else if (roll < 93) begin
          send_txn(CMD_FREE, $urandom());
        end else if (roll < 96) begin
          case ($urandom_range(2))
            0:       addr = $urandom() & ~m;
            1:       addr = ($urandom() & ~m) | (m - 1);
            default: addr = $urandom() | m;
          endcase
          send_txn(CMD_FREE, addr);
        end else if (roll < 98) begin
          send_txn(CMD_INIT, $urandom());
        end else begin
          send_txn(CmdUnused, $urandom());
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_alloc_free_cases();
    test_pool_exhaustion();
    test_random_traffic();
    settle_pool(EndCycles);
    if (n_errors == 0 && expected_replies.size() == 0) begin
      $display("tb_address_pool_allocator_unit: clean");
    end else begin
      $display("tb_address_pool_allocator_unit: errors");
    end
    $finish;
  end

endmodule
